FILE: hdl/ppie_pkg.sv
// ----------------------------------------------------------------------------
// ppie_pkg - shared types and constants of the phase integrator
// word formats, opcodes, cordic angle table
// ----------------------------------------------------------------------------
`default_nettype none
package ppie_pkg;
	localparam int HarmonicsDefault = 8;
	localparam int CordicSteps = 24;
	localparam logic signed [31:0] TwoPiQ24 = 32'sd105414357;
	localparam logic [31:0] InvTwoPiQ32 = 32'd683565276;
	localparam logic signed [33:0] CordicGainQ30 = 34'sd652032874;
	localparam logic [30:0] TimeStepReset = 31'd167772;

	typedef enum logic [2:0] {
		OP_LOAD = 3'd0, OP_START = 3'd1, OP_SAMPLE = 3'd2, OP_END = 3'd3, OP_REPORT = 3'd4
	} op_t;

	typedef struct packed {
		logic [2:0]         op;
		logic [4:0]         coef_index;
		logic signed [31:0] coef_value;
		logic signed [31:0] stimulus;
		logic signed [31:0] time_span;
	} in_word_t;

	typedef struct packed {
		logic               result_kind;
		logic signed [31:0] end_phase;
		logic [62:0]        deviation_sq;
		logic [30:0]        rms_error;
		logic [31:0]        interval_count;
		logic               no_intervals;
	} out_word_t;

	function automatic logic [31:0] atan_bam(input logic [4:0] i);
		unique case (i)
			5'd0: atan_bam = 32'd536870912;  5'd1: atan_bam = 32'd316933406;
			5'd2: atan_bam = 32'd167458907;  5'd3: atan_bam = 32'd85004756;
			5'd4: atan_bam = 32'd42667331;   5'd5: atan_bam = 32'd21354465;
			5'd6: atan_bam = 32'd10679838;   5'd7: atan_bam = 32'd5340245;
			5'd8: atan_bam = 32'd2670163;    5'd9: atan_bam = 32'd1335087;
			5'd10: atan_bam = 32'd667544;    5'd11: atan_bam = 32'd333772;
			5'd12: atan_bam = 32'd166886;    5'd13: atan_bam = 32'd83443;
			5'd14: atan_bam = 32'd41722;     5'd15: atan_bam = 32'd20861;
			5'd16: atan_bam = 32'd10430;     5'd17: atan_bam = 32'd5215;
			5'd18: atan_bam = 32'd2608;      5'd19: atan_bam = 32'd1304;
			5'd20: atan_bam = 32'd652;       5'd21: atan_bam = 32'd326;
			5'd22: atan_bam = 32'd163;       5'd23: atan_bam = 32'd81;
			default: atan_bam = 32'd0;
		endcase
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) sat32 = 32'sh7fffffff;
		else if (v < -66'sd2147483648) sat32 = 32'sh80000000;
		else sat32 = v[31:0];
	endfunction
endpackage
`default_nettype wire

FILE: hdl/ppie_cordic.sv
// ----------------------------------------------------------------------------
// ppie_cordic - iterative rotation cordic
// one micro-rotation per cycle, sin and cos in q4.30
// ----------------------------------------------------------------------------
`default_nettype none
module ppie_cordic (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [31:0]        angle,
	output logic                    done,
	output logic signed [33:0]      sin_val,
	output logic signed [33:0]      cos_val
);
	import ppie_pkg::*;

	logic signed [33:0] x_q, y_q;
	logic signed [32:0] z_q;
	logic [4:0] step_q;
	logic busy_q, flip_q;
	logic [31:0] rot;
	logic rflip;

	always_comb begin
		rflip = (angle[31:30] == 2'd1) || (angle[31:30] == 2'd2);
		rot = rflip ? angle + 32'h80000000 : angle;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			step_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
				flip_q <= rflip;
				x_q <= CordicGainQ30;
				y_q <= '0;
				z_q <= {rot[31], rot};
			end else if (busy_q) begin
				if (!z_q[32]) begin
					x_q <= x_q - (y_q >>> step_q);
					y_q <= y_q + (x_q >>> step_q);
					z_q <= z_q - $signed({1'b0, atan_bam(step_q)});
				end else begin
					x_q <= x_q + (y_q >>> step_q);
					y_q <= y_q - (x_q >>> step_q);
					z_q <= z_q + $signed({1'b0, atan_bam(step_q)});
				end
				if (step_q == 5'(CordicSteps - 1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
				step_q <= step_q + 5'd1;
			end
		end
	end

	assign sin_val = flip_q ? -y_q : y_q;
	assign cos_val = flip_q ? -x_q : x_q;
endmodule
`default_nettype wire

FILE: hdl/ppie_divsqrt.sv
// ----------------------------------------------------------------------------
// ppie_divsqrt - restoring divide then bitwise square root
// 64 divide steps, then 32 root steps
// ----------------------------------------------------------------------------
`default_nettype none
module ppie_divsqrt (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] num,
	input  wire logic [31:0] den,
	output logic             done,
	output logic [30:0]      root
);
	typedef enum logic [1:0] {S_IDLE, S_DIV, S_SQRT} st_t;
	st_t st_q;
	logic [63:0] quo_q, rem64_q, r_q, bit_q;
	logic [32:0] rem_q;
	logic [6:0] cnt_q;
	logic [32:0] trial;

	assign trial = {rem_q[31:0], quo_q[63]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			unique case (st_q)
				S_IDLE: if (start) begin
					quo_q <= num;
					rem_q <= '0;
					cnt_q <= '0;
					st_q <= S_DIV;
				end
				S_DIV: begin
					if (trial >= {1'b0, den}) begin
						rem_q <= trial - {1'b0, den};
						quo_q <= {quo_q[62:0], 1'b1};
					end else begin
						rem_q <= trial;
						quo_q <= {quo_q[62:0], 1'b0};
					end
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd63) begin
						st_q <= S_SQRT;
						cnt_q <= '0;
						r_q <= '0;
						bit_q <= 64'h4000000000000000;
					end
				end
				S_SQRT: begin
					if (cnt_q == 7'd0) rem64_q <= quo_q;
					else begin
						if (rem64_q >= r_q + bit_q) begin
							rem64_q <= rem64_q - (r_q + bit_q);
							r_q <= (r_q >> 1) + bit_q;
						end else r_q <= r_q >> 1;
						bit_q <= bit_q >> 2;
					end
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd32) begin
						st_q <= S_IDLE;
						done <= 1'b1;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign root = (r_q > 64'h7fffffff) ? 31'h7fffffff : r_q[30:0];
endmodule
`default_nettype wire

FILE: hdl/prc_phase_integrator_error.sv
// ----------------------------------------------------------------------------
// prc_phase_integrator_error - prc phase integrator with end-phase error sum
// sequencer drives one shared multiplier, a cordic and a divide/root unit
// ----------------------------------------------------------------------------
// a sample is bound by the cordic (24 micro-rotations plus handoff per harmonic)
//   and the one multiplier
// end: result word after the EMUL, EEND and SQ states; report: waits on the divide/root unit
// one word at a time: stall is high while a word is in work or a result waits
// reset clears phase, sums and counts, sets time_step to its default; coefficient table is unset
`default_nettype none
module prc_phase_integrator_error #(
	parameter int HARMONICS = ppie_pkg::HarmonicsDefault
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire ppie_pkg::in_word_t in_data,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output ppie_pkg::out_word_t     out_data,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [1:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);
	import ppie_pkg::*;
	localparam int Depth = 2 + 2 * HARMONICS;
	localparam int Iw = $clog2(Depth);
	localparam int Hw = $clog2(HARMONICS + 1);

	typedef enum logic [3:0] {
		ST_IDLE, ST_RD, ST_ANG, ST_HSTART, ST_HWAIT, ST_SMUL, ST_CMUL, ST_ACC,
		ST_TMUL, ST_RMUL, ST_PHASE, ST_EMUL, ST_EEND, ST_SQ, ST_RPT, ST_OUT
	} st_t;
	st_t st_q;

	// coefficient memory, one read port registered
	logic signed [31:0] coef_mem [Depth];
	logic signed [31:0] rd_q;
	logic [Iw-1:0] rd_addr;

	logic signed [31:0] freq_q, phase_q, prev_q, prc_q, avg_q, span_q;
	logic signed [32:0] dev_q;
	logic [63:0] sum_q;
	logic [31:0] cnt_q, bam_q, ang_q;
	logic [30:0] ts_q;
	logic [Hw-1:0] harm_q;
	logic signed [65:0] acc_q;
	in_word_t w_q;
	out_word_t res_q;

	// shared multiplier, operands chosen by the sequencer
	logic signed [33:0] ma, mb;
	logic signed [67:0] prod;
	logic signed [67:0] prod_q;
	assign prod = ma * mb;

	logic cs_start, cs_done, ds_start, ds_done;
	logic signed [33:0] sin_v, cos_v;
	logic [30:0] root;
	logic ds_busy_q;

	ppie_cordic u_cordic (.clk, .arst_n, .start(cs_start), .angle(ang_q), .done(cs_done),
		.sin_val(sin_v), .cos_val(cos_v));
	ppie_divsqrt u_divsqrt (.clk, .arst_n, .start(ds_start), .num(sum_q), .den(cnt_q),
		.done(ds_done), .root(root));

	assign cs_start = (st_q == ST_HSTART);
	assign ds_start = (st_q == ST_RPT) && (cnt_q != 32'd0) && !ds_busy_q;

	always_comb begin
		ma = '0;
		mb = '0;
		unique case (st_q)
			ST_ANG:  begin ma = 34'(phase_q); mb = $signed({2'b0, InvTwoPiQ32}); end
			ST_SMUL: begin ma = 34'(rd_q); mb = sin_v; end
			ST_CMUL: begin ma = 34'(rd_q); mb = cos_v; end
			ST_TMUL: begin ma = 34'(prc_q); mb = 34'(avg_q); end
			ST_RMUL: begin ma = 34'(sat32(66'(freq_q) + 66'(prod_q)));
				mb = $signed({3'b0, ts_q}); end
			ST_EMUL: begin ma = 34'(span_q); mb = 34'(freq_q); end
			// square of the end-phase deviation
			ST_SQ:   begin ma = 34'(dev_q); mb = 34'(dev_q); end
			default: ;
		endcase
	end

	always_comb begin
		unique case (st_q)
			ST_SMUL: rd_addr = Iw'(3 + 2 * harm_q);
			ST_HWAIT: rd_addr = Iw'(2 + 2 * harm_q);
			default: rd_addr = Iw'(1);
		endcase
	end

	always_ff @(posedge clk) begin
		rd_q <= coef_mem[rd_addr];
		if (st_q == ST_IDLE && in_valid && in_data.op == OP_LOAD
				&& 32'(in_data.coef_index) < Depth)
			coef_mem[Iw'(in_data.coef_index)] <= in_data.coef_value;
	end

	assign in_stall = (st_q != ST_IDLE);
	assign out_valid = (st_q == ST_OUT);
	assign out_data = res_q;
	assign pready = 1'b1;
	assign prdata = {1'b0, ts_q};

	logic signed [65:0] ephase;
	logic signed [32:0] dev;
	logic [64:0] sum_n;
	logic [31:0] cnt_inc;
	always_comb begin
		ephase = 66'(phase_q) + 66'(prod_q >>> 24);
		dev = 33'(sat32(ephase)) - 33'(TwoPiQ24);
		sum_n = {1'b0, sum_q} + {1'b0, prod[63:0]};
		cnt_inc = (cnt_q != 32'hffffffff) ? cnt_q + 32'd1 : cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			ts_q <= TimeStepReset;
			phase_q <= '0;
			prev_q <= '0;
			sum_q <= '0;
			cnt_q <= '0;
			freq_q <= '0;
			ds_busy_q <= 1'b0;
		end else begin
			if (psel && penable && pwrite && paddr == 2'd0) ts_q <= pwdata[30:0];
			unique case (st_q)
				ST_IDLE: if (in_valid) begin
					w_q <= in_data;
					unique case (in_data.op)
						OP_LOAD: if (in_data.coef_index == 5'd0) freq_q <= in_data.coef_value;
						OP_START: begin prev_q <= in_data.stimulus; span_q <= in_data.time_span;
							st_q <= ST_EMUL; end
						OP_SAMPLE: begin
							avg_q <= 32'((33'(in_data.stimulus) + 33'(prev_q)) >>> 1);
							prev_q <= in_data.stimulus;
							st_q <= ST_ANG;
						end
						OP_END: begin span_q <= in_data.time_span; st_q <= ST_EMUL; end
						OP_REPORT: st_q <= ST_RPT;
						default: ;
					endcase
				end
				ST_ANG: begin bam_q <= prod[55:24]; st_q <= ST_RD; end
				ST_RD: begin
					acc_q <= 66'(rd_q);
					harm_q <= '0;
					ang_q <= bam_q;
					st_q <= ST_HSTART;
				end
				ST_HSTART: st_q <= ST_HWAIT;
				ST_HWAIT: if (cs_done) st_q <= ST_SMUL;
				ST_SMUL: begin acc_q <= acc_q + 66'(prod >>> 30); st_q <= ST_CMUL; end
				ST_CMUL: begin acc_q <= acc_q + 66'(prod >>> 30); st_q <= ST_ACC; end
				ST_ACC: if (harm_q == Hw'(HARMONICS - 1)) begin
					prc_q <= sat32(acc_q);
					st_q <= ST_TMUL;
				end else begin
					harm_q <= harm_q + Hw'(1);
					ang_q <= ang_q + bam_q;
					st_q <= ST_HSTART;
				end
				ST_TMUL: begin prod_q <= 68'(sat32(66'(prod >>> 24))); st_q <= ST_RMUL; end
				ST_RMUL: begin prod_q <= prod; st_q <= ST_PHASE; end
				ST_PHASE: begin phase_q <= sat32(66'(phase_q) + 66'(prod_q >>> 24));
					st_q <= ST_IDLE; end
				ST_EMUL: begin
					prod_q <= prod;
					if (w_q.op == OP_START) begin
						phase_q <= sat32(66'(prod >>> 24));
						st_q <= ST_IDLE;
					end else st_q <= ST_EEND;
				end
				ST_EEND: begin
					// end phase and count now, square the deviation on the shared multiplier next
					res_q <= '{1'b0, sat32(ephase), 63'd0, 31'd0, cnt_inc, 1'b0};
					dev_q <= dev;
					cnt_q <= cnt_inc;
					st_q <= ST_SQ;
				end
				ST_SQ: begin
					res_q.deviation_sq <= prod[62:0];
					sum_q <= sum_n[64] ? 64'hffffffffffffffff : sum_n[63:0];
					st_q <= ST_OUT;
				end
				ST_RPT: begin
					if (cnt_q == 32'd0) begin
						res_q <= '{1'b1, 32'sd0, 63'd0, 31'd0, 32'd0, 1'b1};
						st_q <= ST_OUT;
					end else if (ds_done) begin
						res_q <= '{1'b1, 32'sd0, 63'd0, root, cnt_q, 1'b0};
						ds_busy_q <= 1'b0;
						st_q <= ST_OUT;
					end else ds_busy_q <= 1'b1;
				end
				ST_OUT: if (!out_stall) st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: hdl/ppie_checker.sv
// ----------------------------------------------------------------------------
// ppie_checker - port-level properties of the phase integrator
// bound onto the top level
// ----------------------------------------------------------------------------
`default_nettype none
module ppie_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_stall,
	input wire logic                out_valid,
	input wire logic                out_stall,
	input wire ppie_pkg::out_word_t out_data
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("out hold");
	a_busy_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input taken while result pending");
	a_report: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.result_kind |-> out_data.deviation_sq == 63'd0)
		else $error("report carries deviation");
	a_noint: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.no_intervals |-> out_data.interval_count == 32'd0)
		else $error("no_intervals with count");
endmodule

bind prc_phase_integrator_error ppie_checker u_ppie_checker (.clk, .arst_n,
	.in_stall, .out_valid, .out_stall, .out_data);
`default_nettype wire
